// ===== hdl/h264fua_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// H.264 FU-A fragmenter package
// Item types, run descriptors and constants shared by the fragmenter modules.
// ----------------------------------------------------------------------------
package h264fua_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int START_HOLD  = 4;
  localparam int PKT_W       = 12;
  localparam int TOT_W       = LENGTH_BITS + 1;
  localparam int HOLD_CNT_W  = $clog2(START_HOLD + 1);
  localparam int HOLD_IDX_W  = $clog2(START_HOLD);
  localparam int MAX_RUN     = START_HOLD + 1;
  localparam int RUN_CNT_W   = $clog2(MAX_RUN + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PKT_W-1:0] RESET_PACKET = 12'd1400;
  localparam logic [PKT_W-1:0] MIN_PACKET   = 12'd16;
  localparam logic [7:0]       FU_A_TYPE    = 8'd28;
  localparam logic [7:0]       NRI_MASK     = 8'hE0;
  localparam logic [7:0]       TYPE_MASK    = 8'h1F;
  localparam logic [7:0]       FU_START_BIT = 8'h80;
  localparam logic [7:0]       FU_END_BIT   = 8'h40;

  typedef enum logic [6:0] {
    PH_IDLE         = 7'b0000001,
    PH_HOLD         = 7'b0000010,
    PH_SINGLE_FIRST = 7'b0000100,
    PH_SINGLE_MORE  = 7'b0001000,
    PH_FRAG_HEAD    = 7'b0010000,
    PH_FRAG_FIRST   = 7'b0100000,
    PH_FRAG_MORE    = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic                   first_of_unit;
    logic [LENGTH_BITS-1:0] unit_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_start;
    logic       packet_end;
    logic       is_fragment;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_start;
    logic       packet_end;
    logic       is_fragment;
  } rec_t;

  typedef struct packed {
    logic [RUN_CNT_W-1:0]   count;
    rec_t [MAX_RUN-1:0]     recs;
  } run_t;

endpackage
`default_nettype wire

// ===== hdl/h264fua_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// H.264 FU-A fragmenter front end
// Accepts NAL unit bytes, strips the start code, tracks packet state and
// turns each byte into a run of result records for the queue.
// ----------------------------------------------------------------------------
module h264fua_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [h264fua_pkg::PKT_W-1:0] cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  h264fua_pkg::in_item_t        in_data_i,
  input  wire                          q_full_i,
  output logic                         push_o,
  output h264fua_pkg::run_t            run_o
);
  import h264fua_pkg::*;

  logic [PKT_W-1:0]       max_size_q;
  logic [PKT_W-1:0]       unit_max_q, unit_max_d;
  logic [7:0]             held_q [START_HOLD];
  logic [7:0]             held_d [START_HOLD];
  logic [HOLD_CNT_W-1:0]  held_count_q, held_count_d;
  logic [LENGTH_BITS-1:0] bytes_left_q, bytes_left_d;
  logic [7:0]             header_q, header_d;
  logic [PKT_W-1:0]       fill_q, fill_d;
  phase_e                 phase_q, phase_d;
  logic                   in_fire;

  assign in_ready_o = !q_full_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    logic [HOLD_CNT_W-1:0] sc;
    logic [TOT_W-1:0]      rest;
    logic [PKT_W-1:0]      room;
    logic [RUN_CNT_W-1:0]  n;
    logic                  frag_end;
    logic [7:0]            b;

    b            = in_data_i.data_byte;
    held_d       = held_q;
    held_count_d = held_count_q;
    bytes_left_d = bytes_left_q;
    header_d     = header_q;
    fill_d       = fill_q;
    unit_max_d   = unit_max_q;
    phase_d      = phase_q;
    run_o        = '0;
    n            = '0;
    sc           = '0;
    rest         = '0;
    room         = '0;
    frag_end     = 1'b0;

    if (in_fire && in_data_i.first_of_unit) begin
      held_count_d = '0;
      fill_d       = '0;
      bytes_left_d = in_data_i.unit_length;
      unit_max_d   = (max_size_q < MIN_PACKET) ? MIN_PACKET : max_size_q;
      phase_d      = (in_data_i.unit_length == '0) ? PH_IDLE : PH_HOLD;
    end

    if (in_fire) begin
      if (phase_d == PH_IDLE || bytes_left_d == '0) begin
        phase_d = PH_IDLE;
      end else begin
        bytes_left_d = bytes_left_d - LENGTH_BITS'(1);
        room         = unit_max_d - PKT_W'(2);
        case (phase_d)
          PH_HOLD: begin
            if (held_count_d < HOLD_CNT_W'(START_HOLD)) begin
              held_d[held_count_d[HOLD_IDX_W-1:0]] = b;
              held_count_d = held_count_d + HOLD_CNT_W'(1);
            end
            if (held_count_d == HOLD_CNT_W'(START_HOLD) || bytes_left_d == '0) begin
              if (held_count_d >= HOLD_CNT_W'(3) && held_d[0] == 8'h00 &&
                  held_d[1] == 8'h00 && held_d[2] == 8'h01) begin
                sc = HOLD_CNT_W'(3);
              end else if (held_count_d >= HOLD_CNT_W'(4) && held_d[0] == 8'h00 &&
                           held_d[1] == 8'h00 && held_d[2] == 8'h00 &&
                           held_d[3] == 8'h01) begin
                sc = HOLD_CNT_W'(4);
              end
              rest = TOT_W'(held_count_d) + TOT_W'(bytes_left_d) - TOT_W'(sc);
              if (rest == '0) begin
                phase_d = PH_IDLE;
              end else if (rest <= TOT_W'(unit_max_d)) begin
                for (int i = 0; i < START_HOLD; i++) begin
                  if (HOLD_CNT_W'(i) >= sc && HOLD_CNT_W'(i) < held_count_d) begin
                    run_o.recs[n].out_byte     = held_d[i];
                    run_o.recs[n].packet_start = (n == '0);
                    run_o.recs[n].packet_end   = (HOLD_CNT_W'(i + 1) == held_count_d) &&
                                                 (bytes_left_d == '0);
                    run_o.recs[n].is_fragment  = 1'b0;
                    n = n + RUN_CNT_W'(1);
                  end
                end
                phase_d = (held_count_d > sc) ? PH_SINGLE_MORE : PH_SINGLE_FIRST;
              end else begin
                // Fragmenting needs a full hold, so the start code is 0, 3 or 4 bytes.
                fill_d = '0;
                if (sc == HOLD_CNT_W'(4)) begin
                  phase_d = PH_FRAG_HEAD;
                end else if (sc == HOLD_CNT_W'(3)) begin
                  header_d = held_d[3];
                  phase_d  = PH_FRAG_FIRST;
                end else begin
                  header_d = held_d[0];
                  run_o.recs[0] = '{out_byte: (held_d[0] & NRI_MASK) | FU_A_TYPE,
                                    packet_start: 1'b1, packet_end: 1'b0,
                                    is_fragment: 1'b1};
                  run_o.recs[1] = '{out_byte: (held_d[0] & TYPE_MASK) | FU_START_BIT,
                                    packet_start: 1'b0, packet_end: 1'b0,
                                    is_fragment: 1'b1};
                  for (int i = 1; i < START_HOLD; i++) begin
                    run_o.recs[i + 1] = '{out_byte: held_d[i], packet_start: 1'b0,
                                          packet_end: 1'b0, is_fragment: 1'b1};
                  end
                  n       = RUN_CNT_W'(MAX_RUN);
                  fill_d  = PKT_W'(START_HOLD - 1);
                  phase_d = PH_FRAG_MORE;
                end
              end
            end
          end
          PH_SINGLE_FIRST, PH_SINGLE_MORE: begin
            run_o.recs[0] = '{out_byte: b, packet_start: (phase_d == PH_SINGLE_FIRST),
                              packet_end: (bytes_left_d == '0), is_fragment: 1'b0};
            n       = RUN_CNT_W'(1);
            phase_d = PH_SINGLE_MORE;
          end
          PH_FRAG_HEAD: begin
            header_d = b;
            phase_d  = PH_FRAG_FIRST;
          end
          PH_FRAG_FIRST, PH_FRAG_MORE: begin
            if (fill_d == '0) begin
              run_o.recs[0] = '{out_byte: (header_d & NRI_MASK) | FU_A_TYPE,
                                packet_start: 1'b1, packet_end: 1'b0, is_fragment: 1'b1};
              run_o.recs[1] = '{out_byte: (header_d & TYPE_MASK) |
                                  ((phase_d == PH_FRAG_FIRST) ? FU_START_BIT : 8'h00) |
                                  ((TOT_W'(bytes_left_d) + TOT_W'(1) <= TOT_W'(room)) ?
                                   FU_END_BIT : 8'h00),
                                packet_start: 1'b0, packet_end: 1'b0, is_fragment: 1'b1};
              n = RUN_CNT_W'(2);
            end
            frag_end = (fill_d + PKT_W'(1) == room) || (bytes_left_d == '0);
            run_o.recs[n] = '{out_byte: b, packet_start: 1'b0, packet_end: frag_end,
                              is_fragment: 1'b1};
            n       = n + RUN_CNT_W'(1);
            fill_d  = frag_end ? '0 : fill_d + PKT_W'(1);
            phase_d = PH_FRAG_MORE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
        if (bytes_left_d == '0) begin
          phase_d = PH_IDLE;
        end
      end
    end

    run_o.count = n;
    push_o      = in_fire && (n != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q   <= RESET_PACKET;
      unit_max_q   <= RESET_PACKET;
      held_count_q <= '0;
      bytes_left_q <= '0;
      header_q     <= '0;
      fill_q       <= '0;
      phase_q      <= PH_IDLE;
    end else begin
      if (cfg_we_i) begin
        max_size_q <= cfg_wdata_i;
      end
      unit_max_q   <= unit_max_d;
      held_count_q <= held_count_d;
      bytes_left_q <= bytes_left_d;
      header_q     <= header_d;
      fill_q       <= fill_d;
      phase_q      <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule
`default_nettype wire

// ===== hdl/h264fua_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// H.264 FU-A fragmenter run queue
// Short FIFO of run descriptors between the front end and the serializer.
// ----------------------------------------------------------------------------
module h264fua_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  h264fua_pkg::run_t   push_run_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                head_valid_o,
  output h264fua_pkg::run_t   head_run_o
);
  import h264fua_pkg::*;

  run_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_run_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_run_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/h264fua_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// H.264 FU-A fragmenter serializer
// Sends the records of the head run one item per cycle while out_ready_i is high, and marks the last.
// ----------------------------------------------------------------------------
module h264fua_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    head_valid_i,
  input  h264fua_pkg::run_t      head_run_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output h264fua_pkg::out_item_t out_data_o
);
  import h264fua_pkg::*;

  logic [RUN_CNT_W-1:0] idx_q, idx_d;
  logic                 is_last;
  rec_t                 rec;

  assign rec         = head_run_i.recs[idx_q];
  assign is_last     = (idx_q == head_run_i.count - RUN_CNT_W'(1));
  assign out_valid_o = head_valid_i;
  assign pop_o       = out_valid_o && out_ready_i && is_last;

  assign out_data_o.out_byte     = rec.out_byte;
  assign out_data_o.packet_start = rec.packet_start;
  assign out_data_o.packet_end   = rec.packet_end;
  assign out_data_o.is_fragment  = rec.is_fragment;
  assign out_data_o.run_last     = is_last;

  always_comb begin
    idx_d = idx_q;
    if (out_valid_o && out_ready_i) begin
      idx_d = is_last ? '0 : idx_q + RUN_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/h264fua_nal_fu_a_fragmenter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// H.264 NAL unit to RTP FU-A fragmenter, top level
// A byte's results are offered from a registered run queue entry.
// Input bytes are taken one per cycle while the run queue is not full; a byte
// that opens a fragment yields three result items and the start code release
// up to five, and the output port sends one result item per cycle while ready.
// Reset clears all control state and sets the packet size to 1400.
// ----------------------------------------------------------------------------
module h264_nal_fu_a_fragmenter_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [h264fua_pkg::PKT_W-1:0] cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  h264fua_pkg::in_item_t        in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output h264fua_pkg::out_item_t       out_data_o
);
  import h264fua_pkg::*;

  logic push, full, pop, head_valid;
  run_t push_run, head_run;

  h264fua_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (full),
    .push_o      (push),
    .run_o       (push_run)
  );

  h264fua_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_run_i   (push_run),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_run_o   (head_run)
  );

  h264fua_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_run_i   (head_run),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb_h264_nal_fu_a_fragmenter_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the H.264 NAL unit to FU-A fragmenter
// Feeds NAL units one byte per item, first from a short table of directed items
// and then as random units under several packet sizes. A fragmenter model kept
// here predicts the output items, but where a directed row gives its own result.
// Each output item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_h264_nal_fu_a_fragmenter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import h264fua_pkg::*;

  localparam int WATCHDOG  = 3000;
  localparam int SETTLE    = 10;
  localparam int BURST     = 300;
  localparam int PREDICTED = -1;
  localparam int DIR_N     = 23;

  typedef struct {
    in_item_t  item;
    int        n_res;
    out_item_t res;
  } dir_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [PKT_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_data_o;

  logic [PKT_W-1:0]       size_reg = RESET_PACKET;
  logic [7:0]             held [START_HOLD];
  int unsigned            held_n   = 0;
  int unsigned            fill     = 0;
  int unsigned            pkt_max  = 1400;
  logic [LENGTH_BITS-1:0] left     = '0;
  logic [7:0]             nal_hdr  = '0;
  phase_e                 ph       = PH_IDLE;

  out_item_t byte_run [$];
  out_item_t awaited [$];

  int errors     = 0;
  int send_idle  = 0;
  int recv_idle  = 0;
  int burst_id   = 0;
  int burst_done = 0;
  int hold_left  = 0;
  int quiet      = 0;
  int fed        = 0;

  dir_row_t dir_rows [DIR_N] = '{
    '{'{8'hAB, 1'b0, 16'hFFFF}, 0, '0},
    '{'{8'h00, 1'b1, 16'h0000}, 0, '0},
    '{'{8'h00, 1'b1, 16'h0003}, 0, '0},
    '{'{8'h00, 1'b0, 16'hA5A5}, 0, '0},
    '{'{8'h01, 1'b0, 16'h5A5A}, 0, '0},
    '{'{8'hFF, 1'b1, 16'h0001}, 1, '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{'{8'h00, 1'b1, 16'h0002}, PREDICTED, '0},
    '{'{8'h00, 1'b0, 16'h0000}, PREDICTED, '0},
    '{'{8'h00, 1'b1, 16'h0007}, 0, '0},
    '{'{8'h00, 1'b0, 16'hFFFF}, 0, '0},
    '{'{8'h00, 1'b0, 16'h0000}, 0, '0},
    '{'{8'h01, 1'b0, 16'h1234}, PREDICTED, '0},
    '{'{8'h65, 1'b0, 16'h0000}, PREDICTED, '0},
    '{'{8'hAA, 1'b0, 16'h0000}, PREDICTED, '0},
    '{'{8'h55, 1'b0, 16'h0000}, PREDICTED, '0},
    '{'{8'h7C, 1'b1, 16'hFFFF}, 0, '0},
    '{'{8'h11, 1'b0, 16'h0000}, 0, '0},
    '{'{8'h22, 1'b0, 16'h0000}, 0, '0},
    '{'{8'h33, 1'b0, 16'h0000}, PREDICTED, '0},
    '{'{8'h00, 1'b1, 16'h0004}, 0, '0},
    '{'{8'h00, 1'b0, 16'h0000}, 0, '0},
    '{'{8'h01, 1'b0, 16'h0000}, 0, '0},
    '{'{8'h41, 1'b0, 16'h0000}, 1, '{8'h41, 1'b1, 1'b1, 1'b0, 1'b1}}
  };

  h264_nal_fu_a_fragmenter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void emit(logic [7:0] b, logic s, logic e, logic f);
    out_item_t r;
    r = '{out_byte: b, packet_start: s, packet_end: e, is_fragment: f, run_last: 1'b0};
    byte_run.push_back(r);
  endfunction

  function automatic void fragment_byte(logic [7:0] b, int unsigned remaining);
    int unsigned room;
    logic [7:0]  fu_hdr;
    logic        last;
    room = pkt_max - 2;
    if (fill == 0) begin
      fu_hdr = nal_hdr & TYPE_MASK;
      if (ph == PH_FRAG_FIRST) fu_hdr = fu_hdr | FU_START_BIT;
      if (remaining <= room) fu_hdr = fu_hdr | FU_END_BIT;
      emit((nal_hdr & NRI_MASK) | FU_A_TYPE, 1'b1, 1'b0, 1'b1);
      emit(fu_hdr, 1'b0, 1'b0, 1'b1);
      ph = PH_FRAG_MORE;
    end
    last = (fill + 1 == room) || (remaining == 1);
    emit(b, 1'b0, last, 1'b1);
    fill = last ? 0 : fill + 1;
  endfunction

  function automatic void release_held();
    int unsigned code_len;
    int unsigned rest;
    code_len = 0;
    if (held_n >= 3 && held[0] == 8'h00 && held[1] == 8'h00 && held[2] == 8'h01) begin
      code_len = 3;
    end else if (held_n >= 4 && held[0] == 8'h00 && held[1] == 8'h00 &&
                 held[2] == 8'h00 && held[3] == 8'h01) begin
      code_len = 4;
    end
    rest = held_n + 32'(left) - code_len;
    if (rest == 0) begin
      ph = PH_IDLE;
      return;
    end
    if (rest <= pkt_max) begin
      ph = PH_SINGLE_FIRST;
      for (int unsigned i = code_len; i < held_n; i++) begin
        emit(held[i], ph == PH_SINGLE_FIRST, (i + 1 == held_n) && (left == 0), 1'b0);
        ph = PH_SINGLE_MORE;
      end
      if (left == 0) ph = PH_IDLE;
      return;
    end
    fill = 0;
    if (code_len >= held_n) begin
      ph = PH_FRAG_HEAD;
      return;
    end
    nal_hdr = held[code_len];
    ph = PH_FRAG_FIRST;
    for (int unsigned i = code_len + 1; i < held_n; i++) begin
      fragment_byte(held[i], held_n - i + 32'(left));
    end
  endfunction

  // Returns whether the item belongs to a unit rather than being ignored.
  function automatic bit predict_byte(in_item_t it);
    bit live;
    byte_run.delete();
    live = it.first_of_unit ? (it.unit_length != 0) : (ph != PH_IDLE && left != 0);
    if (it.first_of_unit) begin
      held_n  = 0;
      fill    = 0;
      left    = it.unit_length;
      pkt_max = (size_reg < MIN_PACKET) ? 32'(MIN_PACKET) : 32'(size_reg);
      ph      = (it.unit_length == 0) ? PH_IDLE : PH_HOLD;
    end
    if (ph == PH_IDLE || left == 0) begin
      ph = PH_IDLE;
      return live;
    end
    left = left - 1'b1;
    case (ph)
      PH_HOLD: begin
        if (held_n < START_HOLD) begin
          held[held_n] = it.data_byte;
          held_n++;
        end
        if (held_n >= START_HOLD || left == 0) release_held();
      end
      PH_SINGLE_FIRST, PH_SINGLE_MORE: begin
        emit(it.data_byte, ph == PH_SINGLE_FIRST, left == 0, 1'b0);
        ph = (left == 0) ? PH_IDLE : PH_SINGLE_MORE;
      end
      PH_FRAG_HEAD: begin
        nal_hdr = it.data_byte;
        ph = PH_FRAG_FIRST;
      end
      default: begin
        fragment_byte(it.data_byte, 32'(left) + 1);
      end
    endcase
    if (left == 0) ph = PH_IDLE;
    if (byte_run.size() > 0) byte_run[byte_run.size() - 1].run_last = 1'b1;
    return live;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic feed(in_item_t it, int n_res = PREDICTED, out_item_t res = '0);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_byte(it)) fed++;
    if (n_res == PREDICTED) begin
      foreach (byte_run[k]) awaited.push_back(byte_run[k]);
    end else if (n_res == 1) begin
      awaited.push_back(res);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_size(logic [PKT_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = v;
  endtask

  task automatic send_unit();
    in_item_t               it;
    logic [7:0]             bytes [$];
    logic [LENGTH_BITS-1:0] unit_len;
    int unsigned            pkt;
    int unsigned            rest;
    int unsigned            total;
    int unsigned            count;
    int unsigned            pick;
    pkt  = (size_reg < MIN_PACKET) ? 32'(MIN_PACKET) : 32'(size_reg);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 3)) begin
        it.data_byte     = 8'($urandom);
        it.first_of_unit = 1'b0;
        it.unit_length   = 16'($urandom);
        feed(it);
      end
      return;
    end
    if (pick < 14) begin
      it.data_byte     = 8'($urandom);
      it.first_of_unit = 1'b1;
      it.unit_length   = '0;
      feed(it);
      return;
    end
    if (pick < 22) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 2))
          0:       bytes.push_back(8'h00);
          1:       bytes.push_back(8'h01);
          default: bytes.push_back(8'($urandom));
        endcase
      end
    end else begin
      case ($urandom_range(0, 2))
        1: begin
          bytes.push_back(8'h00);
          bytes.push_back(8'h00);
          bytes.push_back(8'h01);
        end
        2: begin
          bytes.push_back(8'h00);
          bytes.push_back(8'h00);
          bytes.push_back(8'h00);
          bytes.push_back(8'h01);
        end
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0:       rest = pkt;
        1:       rest = pkt + 1;
        2:       rest = 2 * (pkt - 2) + 1;
        3:       rest = $urandom_range(1, pkt);
        default: rest = $urandom_range(pkt + 2, 2 * pkt);
      endcase
      if (pkt > 64) rest = $urandom_range(1, 40);
      repeat (rest) bytes.push_back(8'($urandom));
    end
    total    = bytes.size();
    count    = total;
    unit_len = LENGTH_BITS'(total);
    pick     = $urandom_range(0, 99);
    if (pick < 10 && total > 1) begin
      count = $urandom_range(1, total - 1);
    end else if (pick < 15) begin
      unit_len = LENGTH_BITS'($urandom_range(total + 1, 65535));
    end
    for (int unsigned k = 0; k < count; k++) begin
      it.data_byte     = bytes[k];
      it.first_of_unit = (k == 0);
      it.unit_length   = (k == 0) ? unit_len : 16'($urandom);
      feed(it);
    end
    if (pick >= 15 && pick < 20) begin
      it.data_byte     = 8'($urandom);
      it.first_of_unit = 1'b0;
      it.unit_length   = 16'($urandom);
      feed(it);
    end
  endtask

  task automatic run_units(int n);
    int start;
    start = fed;
    while (fed - start < n) send_unit();
  endtask

  always @(posedge clk_i) begin
    if (burst_id != burst_done) begin
      burst_done = burst_id;
      hold_left  = BURST;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin : out_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited.size() == 0) begin
        $error("unexpected output item %h", out_data_o);
        errors++;
      end else begin
        want = awaited.pop_front();
        check_field("out_byte", want.out_byte, out_data_o.out_byte);
        check_field("packet_start", 8'(want.packet_start), 8'(out_data_o.packet_start));
        check_field("packet_end", 8'(want.packet_end), 8'(out_data_o.packet_end));
        check_field("is_fragment", 8'(want.is_fragment), 8'(out_data_o.is_fragment));
        check_field("run_last", 8'(want.run_last), 8'(out_data_o.run_last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= WATCHDOG) begin
      $display("tb_h264_nal_fu_a_fragmenter_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 9;
    recv_idle = 83;
    foreach (dir_rows[r]) feed(dir_rows[r].item, dir_rows[r].n_res, dir_rows[r].res);
    set_size(12'd16);
    run_units(5);
    send_idle = 83;
    recv_idle = 9;
    set_size(12'd3);
    run_units(5);
    send_idle = 0;
    recv_idle = 0;
    set_size(12'd4095);
    run_units(3);
    drain();
    run_units(3);
    set_size(12'($urandom_range(17, 48)));
    burst_id++;
    run_units(8);
    drain();
    if (errors == 0) begin
      $display("tb_h264_nal_fu_a_fragmenter_top: clean");
    end else begin
      $display("tb_h264_nal_fu_a_fragmenter_top: errors");
    end
    $finish;
  end

endmodule
